[src/causal_multicast_delivery_assert.svh]
// ---------------------------------------------------------------------------
// Causal multicast delivery: assertion macros
// Shared property forms used by the concurrent checks of the block.
// ---------------------------------------------------------------------------
`ifndef CAUSAL_MULTICAST_DELIVERY_ASSERT_SVH
`define CAUSAL_MULTICAST_DELIVERY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cmd_pkg.sv]
// ---------------------------------------------------------------------------
// Causal multicast delivery package
// Sizes, codes and item types shared by the block's modules.
// ---------------------------------------------------------------------------
`default_nettype none

package cmd_pkg;

    localparam int NODES        = 8;
    localparam int HOLD_DEPTH   = 16;
    localparam int CW           = 32;
    localparam int NODE_W       = $clog2(NODES);
    localparam int CNT_W        = $clog2(NODES + 1);
    localparam int HIDX_W       = $clog2(HOLD_DEPTH);
    localparam int HCNT_W       = $clog2(HOLD_DEPTH + 1);
    localparam int ROW_W        = NODES * CW;

    typedef enum logic [1:0] {
        ACT_SEND = 2'd0,
        ACT_RECV = 2'd1,
        ACT_INIT = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        KIND_SEND    = 3'd0,
        KIND_DELIVER = 3'd1,
        KIND_BUFFER  = 3'd2,
        KIND_HELD    = 3'd3,
        KIND_DROP    = 3'd4,
        KIND_INIT    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CFG_NODE_COUNT  = 2'd0,
        CFG_SELF_ID     = 2'd1,
        CFG_START_VALUE = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND,
        ST_READ,
        ST_CHECK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  sender_id;
        logic        causal_mode;
        logic [31:0] clock_0;
        logic [31:0] clock_1;
        logic [31:0] clock_2;
        logic [31:0] clock_3;
        logic [31:0] clock_4;
        logic [31:0] clock_5;
        logic [31:0] clock_6;
        logic [31:0] clock_7;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  node_id;
        logic [31:0] counter_value;
        logic        violates;
        logic        last;
    } t_out;

endpackage

`default_nettype wire

[src/cmd_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/cmd_lane.sv]
// ---------------------------------------------------------------------------
// Readiness lane
// Tests one vector entry of a message against the local vector clock.
// ---------------------------------------------------------------------------
`default_nettype none

module cmd_lane (
    input  wire logic [cmd_pkg::NODE_W-1:0] i_idx,
    input  wire logic [cmd_pkg::CNT_W-1:0]  i_cnt,
    input  wire logic [cmd_pkg::NODE_W-1:0] i_sender,
    input  wire logic [cmd_pkg::NODE_W-1:0] i_self,
    input  wire logic [cmd_pkg::CW-1:0]     i_local,
    input  wire logic [cmd_pkg::CW-1:0]     i_vec,
    output logic                            o_ok
);

    logic [cmd_pkg::CW-1:0] local_inc;

    assign local_inc = i_local + cmd_pkg::CW'(1);

    always_comb begin
        if (i_idx == i_sender) begin
            // The sender's entry must be exactly one past what we have seen,
            // even when a smaller node count no longer covers the sender.
            o_ok = (local_inc == i_vec);
        end else if ({1'b0, i_idx} >= i_cnt) begin
            o_ok = 1'b1;
        end else if (i_idx == i_self) begin
            o_ok = 1'b1;
        end else begin
            o_ok = (i_vec <= i_local);
        end
    end

endmodule

`default_nettype wire

[src/causal_multicast_delivery.sv]
// ---------------------------------------------------------------------------
// Causal multicast delivery
// Vector clock with a hold-back buffer that orders received messages.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; results then come out
// on o_result, each marked by o_valid for a single cycle, and the receiver
// cannot hold them off. The final result of an item has last set. Init, a
// non-causal receive, a held or a dropped message give one result, which
// passes through the pending and output registers. A send gives one result
// per vector entry in use. A causal delivery is followed by a scan of the
// hold-back buffer from its oldest message; each buffered message goes
// through a read state and a check state because the buffer memory has a
// registered read port, and every delivery from the buffer restarts the scan.
// ---------------------------------------------------------------------------
`default_nettype none

module causal_multicast_delivery (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire cmd_pkg::t_in  i_item,
    output logic               o_valid,
    output cmd_pkg::t_out      o_result,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data
);

    localparam int NODES  = cmd_pkg::NODES;
    localparam int HD     = cmd_pkg::HOLD_DEPTH;
    localparam int CW     = cmd_pkg::CW;
    localparam int NODE_W = cmd_pkg::NODE_W;
    localparam int CNT_W  = cmd_pkg::CNT_W;
    localparam int HIDX_W = cmd_pkg::HIDX_W;
    localparam int HCNT_W = cmd_pkg::HCNT_W;
    localparam int ROW_W  = cmd_pkg::ROW_W;

    // Configuration.
    logic [3:0]        r_node_count;
    logic [NODE_W-1:0] r_self;
    logic [CW-1:0]     r_start_value;

    // Clock state and buffer bookkeeping.
    cmd_pkg::t_state   r_state, n_state;
    logic [CW-1:0]     r_local [NODES];
    logic [CW-1:0]     n_local [NODES];
    logic [NODE_W-1:0] r_hsnd  [HD];
    logic [NODE_W-1:0] n_hsnd  [HD];
    logic [HIDX_W-1:0] r_ord   [HD];
    logic [HIDX_W-1:0] n_ord   [HD];
    logic [HCNT_W-1:0] r_n, n_n;
    logic [HIDX_W-1:0] r_j, n_j;
    logic [NODE_W-1:0] r_i, n_i;
    logic              r_pend_v, n_pend_v;
    cmd_pkg::t_out     r_pend, n_pend;
    logic              r_out_v, n_out_v;
    cmd_pkg::t_out     r_out, n_out;

    logic [CNT_W-1:0]  cnt;
    logic [CW-1:0]     in_vec  [NODES];
    logic [ROW_W-1:0]  in_row;
    logic [ROW_W-1:0]  rd_row;
    logic [CW-1:0]     lane_vec [NODES];
    logic [NODE_W-1:0] lane_sender;
    logic [NODES-1:0]  lane_ok;
    logic              all_ok;
    logic              ram_we;
    logic [HIDX_W-1:0] ram_waddr;
    logic [HIDX_W-1:0] ram_raddr;
    logic              push;
    cmd_pkg::t_out     push_res;
    logic [NODE_W-1:0] s_in;
    logic [NODE_W-1:0] s_buf;

    always_comb begin
        if (r_node_count < 4'd2) begin
            cnt = CNT_W'(2);
        end else if (r_node_count > 4'(NODES)) begin
            cnt = CNT_W'(NODES);
        end else begin
            cnt = CNT_W'(r_node_count);
        end
    end

    assign in_vec[0] = i_item.clock_0;
    assign in_vec[1] = i_item.clock_1;
    assign in_vec[2] = i_item.clock_2;
    assign in_vec[3] = i_item.clock_3;
    assign in_vec[4] = i_item.clock_4;
    assign in_vec[5] = i_item.clock_5;
    assign in_vec[6] = i_item.clock_6;
    assign in_vec[7] = i_item.clock_7;

    assign s_in  = i_item.sender_id;
    assign s_buf = r_hsnd[r_ord[r_j]];

    always_comb begin
        for (int k = 0; k < NODES; k++) begin
            in_row[k*CW +: CW] = in_vec[k];
            lane_vec[k] = (r_state == cmd_pkg::ST_CHECK) ? rd_row[k*CW +: CW] : in_vec[k];
        end
    end

    assign lane_sender = (r_state == cmd_pkg::ST_CHECK) ? s_buf : s_in;

    // One readiness lane per vector entry; the merge is a plain AND.
    for (genvar g = 0; g < NODES; g++) begin : g_lane
        cmd_lane u_lane (
            .i_idx    (NODE_W'(g)),
            .i_cnt    (cnt),
            .i_sender (lane_sender),
            .i_self   (r_self),
            .i_local  (r_local[g]),
            .i_vec    (lane_vec[g]),
            .o_ok     (lane_ok[g])
        );
    end

    assign all_ok = &lane_ok;

    cmd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (HD)
    ) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_row),
        .i_raddr (ram_raddr),
        .o_rdata (rd_row)
    );

    assign ram_waddr = r_ord[r_n[HIDX_W-1:0]];
    assign ram_raddr = r_ord[r_j];

    always_comb begin
        n_state  = r_state;
        n_local  = r_local;
        n_hsnd   = r_hsnd;
        n_ord    = r_ord;
        n_n      = r_n;
        n_j      = r_j;
        n_i      = r_i;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_out_v  = 1'b0;
        n_out    = r_pend;
        ram_we   = 1'b0;
        push     = 1'b0;
        push_res = '0;

        case (r_state)
            cmd_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_item.action)
                        cmd_pkg::ACT_INIT: begin
                            for (int k = 0; k < NODES; k++) begin
                                n_local[k] = r_start_value;
                            end
                            n_n = '0;
                            push = 1'b1;
                            push_res.kind = cmd_pkg::KIND_INIT;
                            push_res.node_id = r_self;
                            push_res.counter_value = r_start_value;
                            n_state = cmd_pkg::ST_FLUSH;
                        end
                        cmd_pkg::ACT_SEND: begin
                            n_local[r_self] = r_local[r_self] + CW'(1);
                            n_i = '0;
                            n_state = cmd_pkg::ST_SEND;
                        end
                        cmd_pkg::ACT_RECV: begin
                            push = 1'b1;
                            push_res.node_id = s_in;
                            push_res.counter_value = in_vec[s_in];
                            n_state = cmd_pkg::ST_FLUSH;
                            if ({1'b0, s_in} >= cnt) begin
                                push_res.kind = cmd_pkg::KIND_DROP;
                            end else if (!i_item.causal_mode) begin
                                n_local[s_in] = in_vec[s_in];
                                push_res.kind = cmd_pkg::KIND_DELIVER;
                                push_res.violates = !all_ok;
                            end else if (all_ok) begin
                                n_local[s_in] = in_vec[s_in];
                                push_res.kind = cmd_pkg::KIND_DELIVER;
                                n_j = '0;
                                if (r_n != '0) begin
                                    n_state = cmd_pkg::ST_READ;
                                end
                            end else if (r_n == HCNT_W'(HD)) begin
                                push_res.kind = cmd_pkg::KIND_DROP;
                            end else begin
                                ram_we = 1'b1;
                                n_hsnd[ram_waddr] = s_in;
                                n_n = r_n + HCNT_W'(1);
                                push_res.kind = cmd_pkg::KIND_HELD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            cmd_pkg::ST_SEND: begin
                push = 1'b1;
                push_res.kind = cmd_pkg::KIND_SEND;
                push_res.node_id = r_i;
                push_res.counter_value = r_local[r_i];
                if ({1'b0, r_i} == cnt - CNT_W'(1)) begin
                    n_state = cmd_pkg::ST_FLUSH;
                end else begin
                    n_i = r_i + NODE_W'(1);
                end
            end
            cmd_pkg::ST_READ: begin
                n_state = cmd_pkg::ST_CHECK;
            end
            cmd_pkg::ST_CHECK: begin
                if (all_ok) begin
                    n_local[s_buf] = rd_row[s_buf*CW +: CW];
                    push = 1'b1;
                    push_res.kind = cmd_pkg::KIND_BUFFER;
                    push_res.node_id = s_buf;
                    push_res.counter_value = rd_row[s_buf*CW +: CW];
                    // Close the gap in arrival order; the freed slot goes to the tail.
                    for (int k = 0; k < HD; k++) begin
                        if (k + 1 < int'(r_n) && k >= int'(r_j)) begin
                            n_ord[k] = r_ord[(k + 1) % HD];
                        end else if (k + 1 == int'(r_n)) begin
                            n_ord[k] = r_ord[r_j];
                        end
                    end
                    n_n = r_n - HCNT_W'(1);
                    n_j = '0;
                    n_state = (r_n == HCNT_W'(1)) ? cmd_pkg::ST_FLUSH : cmd_pkg::ST_READ;
                end else if ({1'b0, r_j} + HCNT_W'(1) == r_n) begin
                    n_state = cmd_pkg::ST_FLUSH;
                end else begin
                    n_j = r_j + HIDX_W'(1);
                    n_state = cmd_pkg::ST_READ;
                end
            end
            cmd_pkg::ST_FLUSH: begin
                n_out_v = 1'b1;
                n_out = r_pend;
                n_out.last = 1'b1;
                n_pend_v = 1'b0;
                n_state = cmd_pkg::ST_IDLE;
            end
            default: begin
                n_state = cmd_pkg::ST_IDLE;
            end
        endcase

        // A result is held back in the pending register so the final one can carry last.
        if (push) begin
            if (r_pend_v) begin
                n_out_v = 1'b1;
                n_out = r_pend;
                n_out.last = 1'b0;
            end
            n_pend = push_res;
            n_pend_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count  <= 4'(NODES);
            r_self        <= '0;
            r_start_value <= '0;
            r_state       <= cmd_pkg::ST_IDLE;
            r_n           <= '0;
            r_j           <= '0;
            r_i           <= '0;
            r_pend_v      <= 1'b0;
            r_out_v       <= 1'b0;
            for (int k = 0; k < NODES; k++) begin
                r_local[k] <= '0;
            end
            for (int k = 0; k < HD; k++) begin
                r_ord[k] <= HIDX_W'(k);
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cmd_pkg::CFG_NODE_COUNT:  r_node_count  <= i_cfg_data[3:0];
                    cmd_pkg::CFG_SELF_ID:     r_self        <= i_cfg_data[NODE_W-1:0];
                    cmd_pkg::CFG_START_VALUE: r_start_value <= i_cfg_data[CW-1:0];
                    default: ;
                endcase
            end
            r_state  <= n_state;
            r_n      <= n_n;
            r_j      <= n_j;
            r_i      <= n_i;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            r_local  <= n_local;
            r_ord    <= n_ord;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hsnd <= n_hsnd;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign busy     = (r_state != cmd_pkg::ST_IDLE);
    assign o_valid  = r_out_v;
    assign o_result = r_out;

`include "causal_multicast_delivery_assert.svh"

    `CMD_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_n <= HCNT_W'(HD), "buffer fill overflow")
    `CMD_ASSERT_NOW(a_idle_empty, i_clk, i_rst_n, !busy, !r_pend_v, "pending result while idle")
    `CMD_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_valid && o_result.last, !o_valid, "result after last")

endmodule

`default_nettype wire
